// ----- sv/clbs_pkg.sv -----
// ----------------------------------------------------------------------------
// clbs_pkg
// shared types and constants of the character lcd bus sequencer
// ----------------------------------------------------------------------------
package clbs_pkg;

    // request codes
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CURSOR = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
    localparam logic [1:0] CFG_LINES    = 2'd1;
    localparam logic [1:0] CFG_COLUMNS  = 2'd2;
    localparam logic [1:0] CFG_TALL     = 2'd3;

    // phases of one enable strobe
    localparam logic [1:0] PH_SETUP   = 2'd0;
    localparam logic [1:0] PH_STROBE  = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    localparam int DEFAULT_MAX_ROWS = 4;

    // hold times in microseconds
    localparam logic [15:0] HOLD_PULSE   = 16'd4;
    localparam logic [15:0] HOLD_SETTLE  = 16'd100;
    localparam logic [15:0] HOLD_POWERUP = 16'd50000;
    localparam logic [12:0] EXTRA_LONG   = 13'd4500;
    localparam logic [12:0] EXTRA_SHORT  = 13'd150;
    localparam logic [12:0] EXTRA_CLEAR  = 13'd2000;

    // instruction bytes
    localparam logic [7:0] INS_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] INS_CLEAR      = 8'h01;
    localparam logic [7:0] INS_ENTRY_MODE = 8'h06;
    localparam logic [7:0] INS_SET_DDRAM  = 8'h80;
    localparam logic [7:0] ROW_OFFSET     = 8'h40;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       power;
        logic       is_init;
        logic [2:0] idx;
        logic       part;
        logic [1:0] phase;
        logic       last;
    } clbs_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic two_parts;
        logic last_xfer;
    } clbs_status_t;

endpackage

// ----- sv/clbs_req_if.sv -----
// ----------------------------------------------------------------------------
// clbs_req_if
// request channel of the character lcd bus sequencer
// ----------------------------------------------------------------------------
interface clbs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       reg_select;
    logic [7:0] byte_value;
    logic [2:0] row;
    logic [6:0] col;

    modport source (output valid, cmd, reg_select, byte_value, row, col, input ready);
    modport sink (input valid, cmd, reg_select, byte_value, row, col, output ready);
endinterface

// ----- sv/clbs_phase_if.sv -----
// ----------------------------------------------------------------------------
// clbs_phase_if
// bus phase channel of the character lcd bus sequencer
// ----------------------------------------------------------------------------
interface clbs_phase_if;
    logic        valid;
    logic        ready;
    logic        rs_level;
    logic        rw_level;
    logic        enable_level;
    logic [7:0]  data_lines;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, rs_level, rw_level, enable_level, data_lines, hold_us,
                    last, input ready);
    modport sink (input valid, rs_level, rw_level, enable_level, data_lines, hold_us,
                  last, output ready);
endinterface

// ----- sv/clbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// clbs_ctrl
// sequencer fsm: walks transfers, nibbles and strobe phases of a request
// ----------------------------------------------------------------------------
module clbs_ctrl
    import clbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  logic [1:0]   req_cmd,
    input  clbs_status_t status,
    output clbs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_POWER = 3'b010,
        ST_XFER  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       part_reg, part_next;
    logic [2:0] idx_reg, idx_next;
    logic       init_reg, init_next;
    logic       final_part;

    assign req_ready  = (state_reg == ST_IDLE);
    assign final_part = !status.two_parts || part_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        part_next  = part_reg;
        idx_next   = idx_reg;
        init_next  = init_reg;
        cmd        = '0;
        cmd.is_init = init_reg;
        cmd.idx     = idx_reg;
        cmd.part    = part_reg;
        cmd.phase   = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load   = req_valid;
                phase_next = PH_SETUP;
                part_next  = 1'b0;
                idx_next   = '0;
                if (req_valid)
                begin
                    if (req_cmd == CMD_INIT)
                    begin
                        init_next  = 1'b1;
                        state_next = ST_POWER;
                    end
                    else if (req_cmd == CMD_WRITE || req_cmd == CMD_CURSOR)
                    begin
                        init_next  = 1'b0;
                        state_next = ST_XFER;
                    end
                end
            end
            ST_POWER:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.power  = 1'b1;
                    state_next = ST_XFER;
                end
            end
            ST_XFER:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (phase_reg == PH_RELEASE)
                    begin
                        phase_next = PH_SETUP;
                        if (!final_part)
                        begin
                            part_next = 1'b1;
                        end
                        else
                        begin
                            part_next = 1'b0;
                            if (status.last_xfer)
                            begin
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 3'd1;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SETUP;
            part_reg  <= 1'b0;
            idx_reg   <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            part_reg  <= part_next;
            idx_reg   <= idx_next;
            init_reg  <= init_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.slot_free)
        else $error("phase emitted into a full output register");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.emit)
        else $error("phase emitted while idle");

    a_last_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |-> (cmd.emit && phase_reg == PH_RELEASE && state_reg == ST_XFER))
        else $error("last flag outside a release phase");

    a_power_then_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POWER && cmd.emit) |=>
        (state_reg == ST_XFER && idx_reg == 3'd0 && phase_reg == PH_SETUP && !part_reg))
        else $error("power-up wait not followed by first transfer");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("strobe phase counter out of range");

endmodule

// ----- sv/clbs_datapath.sv -----
// ----------------------------------------------------------------------------
// clbs_datapath
// config registers, request capture, phase payload and output register
// ----------------------------------------------------------------------------
module clbs_datapath
    import clbs_pkg::*;
#(
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data,
    input  logic         req_reg_select,
    input  logic [7:0]   req_byte_value,
    input  logic [2:0]   req_row,
    input  logic [6:0]   req_col,
    input  logic [1:0]   req_cmd,
    input  clbs_cmd_t    cmd,
    output clbs_status_t status,
    input  logic         out_ready,
    output logic         out_valid,
    output logic         out_rs_level,
    output logic         out_enable_level,
    output logic [7:0]   out_data_lines,
    output logic [15:0]  out_hold_us,
    output logic         out_last
);

    localparam logic [2:0] MaxRowIdx = 3'(MAX_ROWS - 1);

    logic        four_bit_reg;
    logic [2:0]  lines_reg;
    logic [5:0]  columns_reg;
    logic        tall_reg;

    logic        rs_reg;
    logic [7:0]  xbyte_reg, xbyte_next;
    logic [12:0] xextra_reg, xextra_next;

    logic        valid_reg;
    logic        rs_out_reg, en_out_reg, last_out_reg;
    logic [7:0]  data_out_reg;
    logic [15:0] hold_out_reg;

    logic [2:0]  lines_eff;
    logic [7:0]  func_set;
    logic [2:0]  row_clamp;
    logic [7:0]  row_offs;

    logic        x_raw;
    logic [7:0]  x_value;
    logic [12:0] x_extra;
    logic        x_rs;
    logic        last_xfer;
    logic        final_part;
    logic [7:0]  data_next;
    logic [15:0] hold_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b0;
            lines_reg    <= 3'd1;
            columns_reg  <= 6'd16;
            tall_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOUR_BIT: four_bit_reg <= cfg_data[0];
                CFG_LINES:    lines_reg    <= cfg_data[2:0];
                CFG_COLUMNS:  columns_reg  <= cfg_data;
                CFG_TALL:     tall_reg     <= cfg_data[0];
                default:      four_bit_reg <= four_bit_reg;
            endcase
        end
    end

    assign lines_eff = (lines_reg == 3'd0) ? 3'd1 : lines_reg;

    always_comb
    begin
        func_set = 8'h20;
        if (!four_bit_reg)
            func_set = func_set | 8'h10;
        if (lines_eff > 3'd1)
            func_set = func_set | 8'h08;
        if (tall_reg && lines_eff == 3'd1)
            func_set = func_set | 8'h04;
    end

    // request capture: the byte to send and its extra wait
    always_comb
    begin
        row_clamp = req_row;
        if (row_clamp > MaxRowIdx)
            row_clamp = MaxRowIdx;
        if (row_clamp >= lines_eff)
            row_clamp = lines_eff - 3'd1;
        case (row_clamp[1:0])
            2'd0:    row_offs = 8'h00;
            2'd1:    row_offs = ROW_OFFSET;
            2'd2:    row_offs = {2'b00, columns_reg};
            default: row_offs = ROW_OFFSET + {2'b00, columns_reg};
        endcase
        if (req_cmd == CMD_CURSOR)
        begin
            xbyte_next  = INS_SET_DDRAM | ({1'b0, req_col} + row_offs);
            xextra_next = '0;
        end
        else
        begin
            xbyte_next  = req_byte_value;
            xextra_next = '0;
            // clear display and return home take the long wait
            if (!req_reg_select &&
                (req_byte_value == 8'h01 || req_byte_value[7:1] == 7'h01))
                xextra_next = EXTRA_CLEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rs_reg     <= (req_cmd == CMD_WRITE) ? req_reg_select : 1'b0;
            xbyte_reg  <= xbyte_next;
            xextra_reg <= xextra_next;
        end
    end

    // current transfer
    always_comb
    begin
        x_raw     = 1'b0;
        x_value   = xbyte_reg;
        x_extra   = xextra_reg;
        x_rs      = rs_reg;
        last_xfer = 1'b1;
        if (cmd.is_init)
        begin
            x_rs    = 1'b0;
            x_extra = '0;
            if (four_bit_reg)
            begin
                last_xfer = (cmd.idx == 3'd7);
                case (cmd.idx)
                    3'd0:
                    begin
                        x_raw = 1'b1; x_value = {4'h0, NIB_WAKE}; x_extra = EXTRA_LONG;
                    end
                    3'd1:
                    begin
                        x_raw = 1'b1; x_value = {4'h0, NIB_WAKE}; x_extra = EXTRA_LONG;
                    end
                    3'd2:
                    begin
                        x_raw = 1'b1; x_value = {4'h0, NIB_WAKE}; x_extra = EXTRA_SHORT;
                    end
                    3'd3:
                    begin
                        x_raw = 1'b1; x_value = {4'h0, NIB_FOUR_BIT};
                    end
                    3'd4: x_value = func_set;
                    3'd5: x_value = INS_DISPLAY_ON;
                    3'd6:
                    begin
                        x_value = INS_CLEAR; x_extra = EXTRA_CLEAR;
                    end
                    default: x_value = INS_ENTRY_MODE;
                endcase
            end
            else
            begin
                last_xfer = (cmd.idx == 3'd6);
                case (cmd.idx)
                    3'd0:
                    begin
                        x_value = func_set; x_extra = EXTRA_LONG;
                    end
                    3'd1:
                    begin
                        x_value = func_set; x_extra = EXTRA_SHORT;
                    end
                    3'd2, 3'd3: x_value = func_set;
                    3'd4: x_value = INS_DISPLAY_ON;
                    3'd5:
                    begin
                        x_value = INS_CLEAR; x_extra = EXTRA_CLEAR;
                    end
                    default: x_value = INS_ENTRY_MODE;
                endcase
            end
        end
    end

    assign status.last_xfer = last_xfer;
    assign status.two_parts = four_bit_reg && !x_raw;
    assign status.slot_free = !valid_reg || out_ready;
    assign final_part       = !status.two_parts || cmd.part;

    always_comb
    begin
        if (x_raw)
            data_next = {4'h0, x_value[3:0]};
        else if (four_bit_reg)
            data_next = cmd.part ? {4'h0, x_value[3:0]} : {4'h0, x_value[7:4]};
        else
            data_next = x_value;
        if (cmd.phase == PH_RELEASE)
            hold_next = HOLD_SETTLE + (final_part ? {3'b000, x_extra} : 16'd0);
        else
            hold_next = HOLD_PULSE;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.power)
            begin
                rs_out_reg   <= 1'b0;
                en_out_reg   <= 1'b0;
                data_out_reg <= 8'h00;
                hold_out_reg <= HOLD_POWERUP;
            end
            else
            begin
                rs_out_reg   <= x_rs;
                en_out_reg   <= (cmd.phase == PH_STROBE);
                data_out_reg <= data_next;
                hold_out_reg <= hold_next;
            end
            last_out_reg <= cmd.last;
        end
    end

    assign out_valid        = valid_reg;
    assign out_rs_level     = rs_out_reg;
    assign out_enable_level = en_out_reg;
    assign out_data_lines   = data_out_reg;
    assign out_hold_us      = hold_out_reg;
    assign out_last         = last_out_reg;

endmodule

// ----- sv/char_lcd_bus_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// turns lcd requests into a stream of timed parallel bus phases
// ----------------------------------------------------------------------------
// usage:
//   req carries one request a beat: write byte, set cursor or power-up init.
//   phase delivers one bus phase a beat: rs, rw, e and data levels plus the
//   hold time in microseconds; last marks the final phase of a request.
//   cfg_we/cfg_index/cfg_data set bus width, line count, column count and
//   font; write them only while no request is in flight.
// timing:
//   a request is taken on its req beat, then its phases leave at one a cycle
//   through the output register while phase.ready stays high. a request
//   yields 3 phases (8-bit byte), 6 (4-bit byte), 22 (8-bit init) or 37
//   (4-bit init). the phase counter in the fsm sets this pace; the first
//   phase follows the fsm state register and then the output register.
//   req.ready is high whenever the fsm is idle, even while the last phase
//   still waits in the output register. a cmd code of 3 is taken and dropped.
// reset and stall:
//   reset returns to idle with an empty output register and the register
//   defaults (8-bit bus, one line, 16 columns, small font). when phase.ready
//   is low the current phase holds and the sequencer waits.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer
    import clbs_pkg::*;
#(
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS
)
(
    input  logic          clk,
    input  logic          rst_n,
    clbs_req_if.sink      req,
    clbs_phase_if.source  phase,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [5:0]    cfg_data
);

    clbs_cmd_t    cmd;
    clbs_status_t status;

    clbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.cmd),
        .status    (status),
        .cmd       (cmd)
    );

    clbs_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_reg_select   (req.reg_select),
        .req_byte_value   (req.byte_value),
        .req_row          (req.row),
        .req_col          (req.col),
        .req_cmd          (req.cmd),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (phase.ready),
        .out_valid        (phase.valid),
        .out_rs_level     (phase.rs_level),
        .out_enable_level (phase.enable_level),
        .out_data_lines   (phase.data_lines),
        .out_hold_us      (phase.hold_us),
        .out_last         (phase.last)
    );

    // writes only
    assign phase.rw_level = 1'b0;

endmodule

// ----- tb/lcd_phase_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd_phase_tracker_pkg
// expected bus phase tracking for the character lcd bus sequencer bench
// ----------------------------------------------------------------------------
package lcd_phase_tracker_pkg;
    import clbs_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // return home, bit 0 is don't care
    localparam logic [7:0] INS_HOME = 8'h02;

    // function set instruction bits
    localparam logic [7:0] FS_BASE      = 8'h20;
    localparam logic [7:0] FS_EIGHT_BIT = 8'h10;
    localparam logic [7:0] FS_TWO_LINE  = 8'h08;
    localparam logic [7:0] FS_TALL_FONT = 8'h04;

    typedef struct packed {
        logic [1:0] cmd;
        logic       reg_select;
        logic [7:0] value;
        logic [2:0] row;
        logic [6:0] col;
    } lcd_request_t;

    typedef struct packed {
        logic        rs_level;
        logic        rw_level;
        logic        enable_level;
        logic [7:0]  data_lines;
        logic [15:0] hold_us;
        logic        last;
    } bus_phase_t;

    class lcd_phase_tracker;
        logic       four_bit_bus;
        logic [2:0] line_count;
        logic [5:0] column_count;
        logic       tall_font;
        bus_phase_t pending_phases[$];
        int         error_count;

        function new();
            four_bit_bus = 1'b0;
            line_count   = 3'd1;
            column_count = 6'd16;
            tall_font    = 1'b0;
            error_count  = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [5:0] value);
            case (index)
                CFG_FOUR_BIT: four_bit_bus = value[0];
                CFG_LINES:    line_count   = value[2:0];
                CFG_COLUMNS:  column_count = value;
                CFG_TALL:     tall_font    = value[0];
                default: ;
            endcase
        endfunction

        function logic [2:0] lines_in_use();
            return (line_count == 3'd0) ? 3'd1 : line_count;
        endfunction

        function void add_phase(logic rs, logic en, logic [7:0] data, logic [15:0] hold);
            bus_phase_t p;
            p.rs_level     = rs;
            p.rw_level     = 1'b0;
            p.enable_level = en;
            p.data_lines   = data;
            p.hold_us      = hold;
            p.last         = 1'b0;
            pending_phases.push_back(p);
        endfunction

        // setup, strobe, release; any extra wait lands on the release
        function void add_strobe(logic rs, logic [7:0] data, logic [15:0] extra);
            add_phase(rs, 1'b0, data, HOLD_PULSE);
            add_phase(rs, 1'b1, data, HOLD_PULSE);
            add_phase(rs, 1'b0, data, HOLD_SETTLE + extra);
        endfunction

        function void add_byte(logic rs, logic [7:0] value, logic [15:0] extra);
            if (four_bit_bus)
            begin
                add_strobe(rs, {4'h0, value[7:4]}, 16'd0);
                add_strobe(rs, {4'h0, value[3:0]}, extra);
            end
            else
            begin
                add_strobe(rs, value, extra);
            end
        endfunction

        function void note_request(lcd_request_t r);
            int         start_size;
            logic [2:0] row;
            logic [7:0] offset;
            logic [7:0] address;
            logic [7:0] function_set;
            logic [15:0] extra;
            bus_phase_t tail;
            start_size = pending_phases.size();
            case (r.cmd)
                CMD_WRITE:
                begin
                    extra = 16'd0;
                    if (!r.reg_select && (r.value == INS_CLEAR || r.value[7:1] == INS_HOME[7:1]))
                        extra = 16'(EXTRA_CLEAR);
                    add_byte(r.reg_select, r.value, extra);
                end
                CMD_CURSOR:
                begin
                    row = r.row;
                    if (row >= DEFAULT_MAX_ROWS)
                        row = 3'(DEFAULT_MAX_ROWS - 1);
                    if (row >= lines_in_use())
                        row = lines_in_use() - 3'd1;
                    case (row[1:0])
                        2'd0:    offset = 8'h00;
                        2'd1:    offset = ROW_OFFSET;
                        2'd2:    offset = {2'b00, column_count};
                        default: offset = ROW_OFFSET + {2'b00, column_count};
                    endcase
                    address = INS_SET_DDRAM | (offset + {1'b0, r.col});
                    add_byte(1'b0, address, 16'd0);
                end
                CMD_INIT:
                begin
                    function_set = FS_BASE;
                    if (!four_bit_bus)
                        function_set = function_set | FS_EIGHT_BIT;
                    if (lines_in_use() > 3'd1)
                        function_set = function_set | FS_TWO_LINE;
                    if (tall_font && lines_in_use() == 3'd1)
                        function_set = function_set | FS_TALL_FONT;
                    add_phase(1'b0, 1'b0, 8'h00, HOLD_POWERUP);
                    if (four_bit_bus)
                    begin
                        add_strobe(1'b0, {4'h0, NIB_WAKE}, 16'(EXTRA_LONG));
                        add_strobe(1'b0, {4'h0, NIB_WAKE}, 16'(EXTRA_LONG));
                        add_strobe(1'b0, {4'h0, NIB_WAKE}, 16'(EXTRA_SHORT));
                        add_strobe(1'b0, {4'h0, NIB_FOUR_BIT}, 16'd0);
                    end
                    else
                    begin
                        add_byte(1'b0, function_set, 16'(EXTRA_LONG));
                        add_byte(1'b0, function_set, 16'(EXTRA_SHORT));
                        add_byte(1'b0, function_set, 16'd0);
                    end
                    add_byte(1'b0, function_set, 16'd0);
                    add_byte(1'b0, INS_DISPLAY_ON, 16'd0);
                    add_byte(1'b0, INS_CLEAR, 16'(EXTRA_CLEAR));
                    add_byte(1'b0, INS_ENTRY_MODE, 16'd0);
                end
                default: ;
            endcase
            if (pending_phases.size() > start_size)
            begin
                tail = pending_phases.pop_back();
                tail.last = 1'b1;
                pending_phases.push_back(tail);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h got %0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_phase(bus_phase_t got);
            bus_phase_t want;
            if (pending_phases.size() == 0)
            begin
                $error("phase beat with nothing pending: data_lines %0h hold_us %0d",
                       got.data_lines, got.hold_us);
                error_count++;
                return;
            end
            want = pending_phases.pop_front();
            compare_field("rs_level", 16'(want.rs_level), 16'(got.rs_level));
            compare_field("rw_level", 16'(want.rw_level), 16'(got.rw_level));
            compare_field("enable_level", 16'(want.enable_level), 16'(got.enable_level));
            compare_field("data_lines", 16'(want.data_lines), 16'(got.data_lines));
            compare_field("hold_us", want.hold_us, got.hold_us);
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

endpackage

// ----- tb/tb_char_lcd_bus_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_char_lcd_bus_sequencer
// drives lcd requests under random gaps and stalls and checks every bus phase
// against a behavioral prediction across several display settings
// ----------------------------------------------------------------------------
module tb_char_lcd_bus_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import clbs_pkg::*;
    import lcd_phase_tracker_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [5:0] cfg_data;
    logic       hold_off;
    logic       no_idle;
    int         accepted_requests = 0;

    lcd_phase_tracker phase_tracker;

    clbs_req_if   req_if();
    clbs_phase_if ph_if();

    char_lcd_bus_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .phase     (ph_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[char_lcd_bus_sequencer] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic lcd_request_t make_request(logic [1:0] cmd, logic reg_select,
                                                  logic [7:0] value, logic [2:0] row,
                                                  logic [6:0] col);
        lcd_request_t r;
        r.cmd        = cmd;
        r.reg_select = reg_select;
        r.value      = value;
        r.row        = row;
        r.col        = col;
        return r;
    endfunction

    function automatic lcd_request_t random_request();
        lcd_request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.cmd = CMD_WRITE;
        else if (pick < 88)
            r.cmd = CMD_CURSOR;
        else if (pick < 95)
            r.cmd = CMD_INIT;
        else
            r.cmd = CMD_UNKNOWN;
        r.reg_select = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       r.value = INS_CLEAR;
                1:       r.value = INS_HOME;
                2:       r.value = INS_HOME | 8'h01;
                default: r.value = 8'hFF;
            endcase
        end
        else
        begin
            r.value = 8'($urandom_range(0, 255));
        end
        r.row = 3'($urandom_range(0, 7));
        r.col = ($urandom_range(0, 5) == 0) ? 7'h7F : 7'($urandom_range(0, 127));
        return r;
    endfunction

    // called right after a rising edge; returns at the edge that takes the beat
    task automatic send_request(lcd_request_t r);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= r.cmd;
        req_if.reg_select <= r.reg_select;
        req_if.byte_value <= r.value;
        req_if.row        <= r.row;
        req_if.col        <= r.col;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        phase_tracker.note_request(r);
        accepted_requests++;
    endtask

    task automatic wait_idle(int settle_cycles);
        req_if.valid <= 1'b0;
        while (phase_tracker.pending_phases.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [5:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        phase_tracker.write_register(index, value);
    endtask

    // a dropped request never leaves idle; wait until no phase is pending, then settle
    task automatic configure(logic four_bit, logic [2:0] lines, logic [5:0] columns,
                             logic tall);
        wait_idle(8);
        write_register(CFG_FOUR_BIT, {5'd0, four_bit});
        write_register(CFG_LINES, {3'd0, lines});
        write_register(CFG_COLUMNS, columns);
        write_register(CFG_TALL, {5'd0, tall});
        cfg_we <= 1'b0;
    endtask

    // phase sink with random stalls and one long hold-off
    initial
    begin
        int stall;
        bus_phase_t got;
        stall = 0;
        ph_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ph_if.valid === 1'b1 && ph_if.ready === 1'b1)
            begin
                got.rs_level     = ph_if.rs_level;
                got.rw_level     = ph_if.rw_level;
                got.enable_level = ph_if.enable_level;
                got.data_lines   = ph_if.data_lines;
                got.hold_us      = ph_if.hold_us;
                got.last         = ph_if.last;
                phase_tracker.check_phase(got);
            end
            if (rst_n !== 1'b1 || hold_off)
            begin
                ph_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                ph_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                ph_if.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // back up the phase side until the request side stalls too
    initial
    begin
        hold_off <= 1'b0;
        while (accepted_requests < 35)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        lcd_request_t r;
        int done_items;
        phase_tracker = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_FOUR_BIT;
        cfg_data          <= 6'd0;
        no_idle           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= CMD_WRITE;
        req_if.reg_select <= 1'b0;
        req_if.byte_value <= 8'h00;
        req_if.row        <= 3'd0;
        req_if.col        <= 7'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: byte bus, one line, 16 columns
        send_request(make_request(CMD_WRITE, 1'b1, 8'h00, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b1, 8'hFF, 3'd7, 7'h7F));
        send_request(make_request(CMD_WRITE, 1'b0, 8'hA5, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, INS_CLEAR, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, INS_HOME, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, INS_HOME | 8'h01, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b1, INS_CLEAR, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, 8'h04, 3'd0, 7'd0));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd0, 7'd0));
        send_request(make_request(CMD_CURSOR, 1'b1, 8'hFF, 3'd7, 7'h7F));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd1, 7'd5));
        send_request(make_request(CMD_INIT, 1'b0, 8'h00, 3'd0, 7'd0));
        send_request(make_request(CMD_UNKNOWN, 1'b1, 8'hFF, 3'd7, 7'h7F));

        // nibble bus, four lines: every row offset and the clamp
        configure(1'b1, 3'd4, 6'd40, 1'b1);
        send_request(make_request(CMD_WRITE, 1'b1, 8'hF0, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, INS_CLEAR, 3'd0, 7'd0));
        send_request(make_request(CMD_WRITE, 1'b0, 8'h0F, 3'd0, 7'd0));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd0, 7'h7F));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd1, 7'd0));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd2, 7'd3));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd3, 7'h7F));
        send_request(make_request(CMD_CURSOR, 1'b0, 8'h00, 3'd6, 7'd1));
        send_request(make_request(CMD_INIT, 1'b0, 8'h00, 3'd0, 7'd0));

        // tall font on a single line display
        configure(1'b0, 3'd1, 6'd16, 1'b1);
        send_request(make_request(CMD_INIT, 1'b0, 8'h00, 3'd0, 7'd0));

        for (int s = 0; s < 8; s++)
        begin
            case (s)
                0:       configure(1'b0, 3'd2, 6'd40, 1'b0);
                1:       configure(1'b1, 3'd1, 6'd16, 1'b1);
                2:       configure(1'b0, 3'd0, 6'd0, 1'b1);
                3:       configure(1'b1, 3'd4, 6'd63, 1'b0);
                4:       configure(1'b0, 3'd7, 6'd1, 1'b1);
                5:       configure(1'b1, 3'd3, 6'd0, 1'b1);
                default: configure(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                   6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            endcase
            done_items = 0;
            while (done_items < 22)
            begin
                no_idle <= (s % 2 == 1) && done_items >= 8 && done_items < 16;
                r = random_request();
                send_request(r);
                if (r.cmd != CMD_UNKNOWN)
                    done_items++;
            end
        end

        wait_idle(20);
        if (phase_tracker.error_count == 0)
            $display("[char_lcd_bus_sequencer] OK");
        else
            $display("[char_lcd_bus_sequencer] ERROR");
        $finish;
    end

endmodule
